FILE: design/hsl2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared constants and a helper function for the integer HSL to RGB pipeline.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

	// number of register stages from input transfer to result strobe
	localparam int unsigned PIPE_DEPTH = 6;

	localparam int unsigned NUM_CH = 3;
	localparam int unsigned CH_RED   = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE  = 2;

	localparam logic [6:0] PCT_MAX   = 7'd100;
	localparam logic [6:0] LIGHT_MID = 7'd50;

	localparam logic [8:0] DEG_THIRD      = 9'd120;
	localparam logic [8:0] DEG_HALF       = 9'd180;
	localparam logic [8:0] DEG_TWO_THIRDS = 9'd240;
	localparam logic [8:0] DEG_SIXTH      = 9'd60;
	localparam logic [15:0] DEG_TURN      = 16'd360;

	// floor(h/360) = (h * HUE_RECIP) >> HUE_SHIFT, exact for every 16-bit h
	localparam logic [31:0] HUE_RECIP = 32'd46604;
	localparam int unsigned HUE_SHIFT = 24;

	// ramp*255/600000 = ((ramp*17) >> 6) / 625, and /625 as a reciprocal
	localparam logic [35:0] LEVEL_RECIP = 36'd214749;
	localparam int unsigned LEVEL_SHIFT = 27;

	localparam logic [5:0] WEIGHT_FULL = 6'd60;

	// ramp position on the span between the two helper levels, 0..60
	function automatic logic [5:0] ramp_weight(input logic [8:0] h);
		logic [8:0] fall;
		fall = DEG_TWO_THIRDS - h;
		if (h < DEG_SIXTH) begin
			return h[5:0];
		end else if (h < DEG_HALF) begin
			return WEIGHT_FULL;
		end else if (h < DEG_TWO_THIRDS) begin
			return fall[5:0];
		end else begin
			return 6'd0;
		end
	endfunction

endpackage

FILE: design/hsl_to_rgb_integer.sv
// Registered path: the input transfer reaches the done strobe through stages s1 to s6.
// Throughput: one item per cycle; busy stays low, start is taken every cycle.
// Results show for one cycle with done; the receiver cannot stall the pipe.
// Latency is set by the six register stages; nothing feeds back, so an item enters every cycle.
// Reset (arst_n low, asynchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// hsl_to_rgb_integer
// Integer HSL to RGB conversion, hue in degrees, S and L in percent.
// ----------------------------------------------------------------------------
module hsl_to_rgb_integer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] hue_deg,
	input  logic [7:0]  sat_pct,
	input  logic [7:0]  light_pct,
	output logic        done,
	output logic [7:0]  red_level,
	output logic [7:0]  green_level,
	output logic [7:0]  blue_level
);

	localparam int unsigned NCH = hsl2rgb_pkg::NUM_CH;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	logic [31:0] hprod_s1;
	logic [15:0] hue_s1;
	logic [6:0]  sat_s1, light_s1;

	logic [8:0]  hue_s2;
	logic [13:0] hi_s2;
	logic [6:0]  light_s2;

	logic [13:0] lo_s3, span_s3;
	logic [NCH-1:0][5:0] weight_s3;

	logic [NCH-1:0][19:0] ramp_s4;
	logic [NCH-1:0][17:0] scaled_s5;
	logic [NCH-1:0][7:0]  level_s6;

	logic [7:0]  hue_quot;
	logic [15:0] hue_mod_full;
	logic [14:0] hi_full;
	logic [14:0] lo_full;
	logic [13:0] span_next;
	logic [8:0]  hue_red, hue_blue;
	logic [NCH-1:0][5:0]  weight_next;
	logic [NCH-1:0][19:0] ramp_next;
	logic [NCH-1:0][23:0] times17;
	logic [NCH-1:0][35:0] level_prod;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// stage 1: clamp, start the hue reduction
	always_ff @(posedge clk) begin
		hprod_s1 <= 32'(hue_deg) * hsl2rgb_pkg::HUE_RECIP;
		hue_s1   <= hue_deg;
		sat_s1   <= (sat_pct > 8'(hsl2rgb_pkg::PCT_MAX)) ? hsl2rgb_pkg::PCT_MAX : sat_pct[6:0];
		light_s1 <= (light_pct > 8'(hsl2rgb_pkg::PCT_MAX)) ?
			hsl2rgb_pkg::PCT_MAX : light_pct[6:0];
	end

	// stage 2: hue modulo 360 and the upper helper level
	always_comb begin
		hue_quot     = hprod_s1[hsl2rgb_pkg::HUE_SHIFT +: 8];
		hue_mod_full = hue_s1 - 16'(hue_quot) * hsl2rgb_pkg::DEG_TURN;
		if (light_s1 < hsl2rgb_pkg::LIGHT_MID) begin
			hi_full = 15'(light_s1) * (15'(hsl2rgb_pkg::PCT_MAX) + 15'(sat_s1));
		end else begin
			hi_full = (15'(light_s1) + 15'(sat_s1)) * 15'(hsl2rgb_pkg::PCT_MAX)
				- 15'(sat_s1) * 15'(light_s1);
		end
	end

	always_ff @(posedge clk) begin
		hue_s2   <= hue_mod_full[8:0];
		hi_s2    <= hi_full[13:0];
		light_s2 <= light_s1;
	end

	// stage 3: lower level, span and per-channel ramp weights
	always_comb begin
		lo_full   = 15'(light_s2) * 15'd200 - 15'(hi_s2);
		span_next = hi_s2 - lo_full[13:0];
		hue_red   = (hue_s2 < hsl2rgb_pkg::DEG_TWO_THIRDS) ?
			hue_s2 + hsl2rgb_pkg::DEG_THIRD : hue_s2 - hsl2rgb_pkg::DEG_TWO_THIRDS;
		hue_blue  = (hue_s2 >= hsl2rgb_pkg::DEG_THIRD) ?
			hue_s2 - hsl2rgb_pkg::DEG_THIRD : hue_s2 + hsl2rgb_pkg::DEG_TWO_THIRDS;
		weight_next[hsl2rgb_pkg::CH_RED]   = hsl2rgb_pkg::ramp_weight(hue_red);
		weight_next[hsl2rgb_pkg::CH_GREEN] = hsl2rgb_pkg::ramp_weight(hue_s2);
		weight_next[hsl2rgb_pkg::CH_BLUE]  = hsl2rgb_pkg::ramp_weight(hue_blue);
	end

	always_ff @(posedge clk) begin
		lo_s3     <= lo_full[13:0];
		span_s3   <= span_next;
		weight_s3 <= weight_next;
	end

	// stages 4 to 6, one lane per channel
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			ramp_next[c]  = 20'(lo_s3) * 20'(hsl2rgb_pkg::WEIGHT_FULL)
				+ 20'(span_s3) * 20'(weight_s3[c]);
			times17[c]    = (24'(ramp_s4[c]) << 4) + 24'(ramp_s4[c]);
			level_prod[c] = 36'(scaled_s5[c]) * hsl2rgb_pkg::LEVEL_RECIP;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NCH; c++) begin
			ramp_s4[c]   <= ramp_next[c];
			scaled_s5[c] <= times17[c][23:6];
			level_s6[c]  <= level_prod[c][hsl2rgb_pkg::LEVEL_SHIFT +: 8];
		end
	end

	assign done        = valid_s6;
	assign red_level   = level_s6[hsl2rgb_pkg::CH_RED];
	assign green_level = level_s6[hsl2rgb_pkg::CH_GREEN];
	assign blue_level  = level_s6[hsl2rgb_pkg::CH_BLUE];

endmodule

FILE: design/hsl2rgb_checker.sv
// ----------------------------------------------------------------------------
// hsl2rgb_checker
// Port-level checks on the HSL to RGB pipeline timing and color results.
// ----------------------------------------------------------------------------
module hsl2rgb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [15:0] hue_deg,
	input logic [7:0]  sat_pct,
	input logic [7:0]  light_pct,
	input logic        done,
	input logic [7:0]  red_level,
	input logic [7:0]  green_level,
	input logic [7:0]  blue_level
);

	localparam int unsigned D = hsl2rgb_pkg::PIPE_DEPTH;

	// every transfer gives a strobe after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##D done)
		else $error("missing result after input transfer");

	// no strobe without a matching transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, D))
		else $error("result strobe without input transfer");

	// zero saturation is grey
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(sat_pct, D) == 8'd0 |->
			red_level == green_level && green_level == blue_level)
		else $error("zero saturation result is not grey");

	// pure red at full saturation and half lightness
	a_pure_red: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(hue_deg == 16'd0 && sat_pct >= 8'd100 && light_pct == 8'd50, D) |->
			red_level == 8'd255 && green_level == 8'd0 && blue_level == 8'd0)
		else $error("pure red conversion wrong");

endmodule

bind hsl_to_rgb_integer hsl2rgb_checker u_hsl2rgb_checker (.*);
